@@ sv/pipt_pkg.sv @@
// Shared types and constants for the pending interest probe table.
package pipt_pkg;

   // Field widths of the item and result ports
   localparam int CMD_W   = 1;
   localparam int FP_W    = 32;
   localparam int FACE_W  = 4;
   localparam int STAT_W  = 2;
   localparam int SLOT_W  = 4;

   // Defaults for the top-level parameters
   localparam int SLOTS_DEF      = 16;
   localparam int FACE_COUNT_DEF = 4;

   // Home-slot reduction per key: a multiply in two halves, then the remainder
   localparam int MOD_STEPS     = 3;
   localparam int STEP_W        = $clog2(MOD_STEPS);

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 1'b0,
      CMD_CHECK  = 1'b1
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_BAD_FACE = 2'd1,
      ST_FULL     = 2'd2,
      ST_CHECKED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MOD,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PROBE
   } back_state_type;

   // Classified item handed from front to back (home slot travels beside it)
   typedef struct packed {
      cmd_type           command;
      logic [FP_W-1:0]   fingerprint;
      logic [FACE_W-1:0] face;
      logic              bad_face;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

endpackage

@@ sv/pipt_front.sv @@
// Front end: accepts items, flags bad faces and reduces the key to its home slot.
module pipt_front #(
   parameter int SLOTS      = pipt_pkg::SLOTS_DEF,
   parameter int FACE_COUNT = pipt_pkg::FACE_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pipt_pkg::CMD_W-1:0]     req_command,
   input  logic [pipt_pkg::FP_W-1:0]      req_fingerprint,
   input  logic [pipt_pkg::FACE_W-1:0]    req_face,
   output logic                           push_valid,
   input  logic                           push_ready,
   output pipt_pkg::item_type             push_item,
   output logic [$clog2(SLOTS)-1:0]       push_home
);
   import pipt_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int LO_W   = 16;
   localparam int RCP_W  = FP_W + 1;
   localparam int HI_W   = RCP_W - LO_W;
   localparam int PROD_W = FP_W + RCP_W;
   localparam int QUO_W  = PROD_W - FP_W - IDX_W;
   // Reciprocal of SLOTS rounded up; its product with any 32-bit key,
   // shifted down by 32 + IDX_W, is the exact quotient
   localparam logic [63:0] RCP_WIDE = ((64'd1 << (FP_W + IDX_W)) / 64'(SLOTS)) + 64'd1;
   localparam logic [HI_W-1:0] RCP_HI = RCP_WIDE[RCP_W-1:LO_W];
   localparam logic [LO_W-1:0] RCP_LO = RCP_WIDE[LO_W-1:0];
   localparam logic [FP_W-1:0] SLOTS_FP = FP_W'(SLOTS);
   localparam logic [FACE_W:0] FACES_EXT = (FACE_W+1)'(FACE_COUNT);

   front_state_type   state_ff, state_in;
   item_type          item_ff, item_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PROD_W-1:0] key_wide;
   logic [PROD_W-1:0] part_hi;
   logic [PROD_W-1:0] part_lo;
   logic [QUO_W-1:0]  quot;
   logic [FP_W-1:0]   rem_wide;
   logic              accept;
   logic              last_step;

   assign accept    = req_valid && req_ready;
   assign last_step = (step_ff == STEP_W'(MOD_STEPS - 1));

   // Key times reciprocal, split into a 32x17 and a 32x16 constant product
   assign key_wide = PROD_W'(item_ff.fingerprint);
   assign part_hi  = key_wide * PROD_W'(RCP_HI);
   assign part_lo  = key_wide * PROD_W'(RCP_LO);
   // Quotient from the top product bits; the remainder is what it leaves over
   assign quot     = prod_ff[PROD_W-1:FP_W+IDX_W];
   assign rem_wide = item_ff.fingerprint - FP_W'(quot) * SLOTS_FP;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (req_valid) begin
               state_in = FR_MOD;
            end
         end
         FR_MOD: begin
            if (last_step) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      item_in    = item_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      unique case (state_ff)
         FR_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               item_in.command     = cmd_type'(req_command);
               item_in.fingerprint = req_fingerprint;
               item_in.face        = req_face;
               item_in.bad_face    = ({1'b0, req_face} >= FACES_EXT);
               step_in             = '0;
            end
         end
         FR_MOD: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(0)) begin
               // High half of the reciprocal product
               prod_in = part_hi;
            end else if (step_ff == STEP_W'(1)) begin
               // Shift it up and add the low half
               prod_in = (prod_ff << LO_W) + part_lo;
            end else begin
               rem_in = rem_wide[IDX_W-1:0];
            end
         end
         FR_PUSH: begin
            push_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign push_item = item_ff;
   assign push_home = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff  <= item_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end

`ifndef SYNTHESIS
   a_home_in_range: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (int'(push_home) < SLOTS))
      else $error("home slot out of range");
`endif

endmodule

@@ sv/pipt_queue.sv @@
// Short FIFO that decouples the front end from the probe engine.
module pipt_queue #(
   parameter int DATA_W = pipt_pkg::ITEM_W + $clog2(pipt_pkg::SLOTS_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   import pipt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(QUEUE_DEPTH)) |=> !(count_ff == '0 && !$past(do_pop)))
      else $error("queue lost an entry without a pop");
`endif

endmodule

@@ sv/pipt_back.sv @@
// Probe engine: table memories, linear probe walk and the result register.
module pipt_back #(
   parameter int SLOTS      = pipt_pkg::SLOTS_DEF,
   parameter int FACE_COUNT = pipt_pkg::FACE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  pipt_pkg::item_type            pop_item,
   input  logic [$clog2(SLOTS)-1:0]      pop_home,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pipt_pkg::STAT_W-1:0]   rsp_status,
   output logic [pipt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_found,
   output logic                          rsp_requested
);
   import pipt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Table: keys need no clearing; occupied mark and face vector are swept
   logic [FP_W-1:0]       key_store_ff [SLOTS];
   logic [FACE_COUNT:0]   stat_store_ff [SLOTS];
   logic [FP_W-1:0]       key_rd_ff;
   logic [FACE_COUNT:0]   stat_rd_ff;

   back_state_type        state_ff, state_in;
   item_type              item_ff, item_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      clr_addr_ff, clr_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_req_ff, rsp_req_in;

   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      idx_next;
   logic                  stat_we;
   logic [IDX_W-1:0]      stat_wa;
   logic [FACE_COUNT:0]   stat_wd;
   logic                  ins_we;
   logic                  rsp_load;
   logic                  rsp_free;
   logic                  pop;
   logic                  probe_done;
   logic                  slot_occ;
   logic [FACE_COUNT-1:0] slot_faces;
   logic [FACE_COUNT-1:0] face_mask;
   logic                  key_hit;
   logic                  last_probe;
   logic                  clr_last;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign slot_occ   = stat_rd_ff[FACE_COUNT];
   assign slot_faces = stat_rd_ff[FACE_COUNT-1:0];
   assign face_mask  = FACE_COUNT'(1) << item_ff.face;
   assign key_hit    = (key_rd_ff == item_ff.fingerprint);
   assign last_probe = (count_ff == LAST_IDX);
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   assign clr_last   = (clr_addr_ff == LAST_IDX);

   // A probe ends on an empty slot, on a key hit (check only) or after a full wrap
   always_comb begin
      probe_done = 1'b0;
      if (!slot_occ || last_probe) begin
         probe_done = 1'b1;
      end else if (item_ff.command == CMD_CHECK && key_hit) begin
         probe_done = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (pop && !pop_item.bad_face) begin
               state_in = BK_PROBE;
            end
         end
         BK_PROBE: begin
            if (probe_done) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      pop_ready     = 1'b0;
      rd_addr       = idx_ff;
      ins_we        = 1'b0;
      stat_we       = 1'b0;
      stat_wa       = idx_ff;
      stat_wd       = {1'b1, slot_faces | face_mask};
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_req_in    = rsp_req_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      clr_addr_in   = clr_addr_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            stat_we     = 1'b1;
            stat_wa     = clr_addr_ff;
            stat_wd     = '0;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
         end
         BK_IDLE: begin
            pop_ready = rsp_free;
            if (pop) begin
               item_in  = pop_item;
               idx_in   = pop_home;
               count_in = '0;
               rd_addr  = pop_home;
               if (pop_item.bad_face) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_BAD_FACE;
                  rsp_slot_in   = '0;
                  rsp_found_in  = 1'b0;
                  rsp_req_in    = 1'b0;
               end
            end
         end
         BK_PROBE: begin
            if (probe_done) begin
               rsp_load     = 1'b1;
               rsp_slot_in  = '0;
               rsp_found_in = 1'b0;
               rsp_req_in   = 1'b0;
               if (item_ff.command == CMD_INSERT) begin
                  if (!slot_occ) begin
                     ins_we        = 1'b1;
                     stat_we       = 1'b1;
                     rsp_status_in = ST_INSERTED;
                     rsp_slot_in   = SLOT_W'(idx_ff);
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end else begin
                  rsp_status_in = ST_CHECKED;
                  if (slot_occ && key_hit) begin
                     rsp_slot_in  = SLOT_W'(idx_ff);
                     rsp_found_in = 1'b1;
                     rsp_req_in   = |(slot_faces & face_mask);
                  end
               end
            end else begin
               // Advance to the next slot and start its read now
               idx_in   = idx_next;
               count_in = count_ff + IDX_W'(1);
               rd_addr  = idx_next;
            end
         end
         default: begin
         end
      endcase
   end

   assign pop = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         key_store_ff[idx_ff] <= item_ff.fingerprint;
      end
      key_rd_ff <= key_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stat_we) begin
         stat_store_ff[stat_wa] <= stat_wd;
      end
      stat_rd_ff <= stat_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_req_ff    <= rsp_req_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_requested = rsp_req_ff;

`ifndef SYNTHESIS
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !pop)
      else $error("item popped during table clear");

   a_rsp_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result register overwritten before taken");

   a_insert_into_empty: assert property (@(posedge clock) disable iff (reset)
      ins_we |-> (state_ff == BK_PROBE && !slot_occ && item_ff.command == CMD_INSERT))
      else $error("insert into an occupied slot");

   a_probe_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_PROBE && !probe_done) |=> (count_ff == $past(count_ff) + IDX_W'(1)))
      else $error("probe counter did not advance");
`endif

endmodule

@@ sv/pending_interest_probe_table.sv @@
// Top level of the pending interest probe table.
//
// Open-addressed table of SLOTS entries, each a 32-bit fingerprint, a vector of
// FACE_COUNT requesting-face bits and an occupied mark. An insert (command 0)
// claims the first empty slot from the home slot (fingerprint mod SLOTS) onward,
// wrapping around, stores the key and sets the face bit; a duplicate fingerprint
// takes a new slot. A check (command 1) walks the same path until an empty slot,
// a matching key or a full wrap, and reports whether the match has the face bit.
// Status: 0 inserted, 1 face out of range, 2 table full, 3 check answered; slot is
// 0 when nothing was written or matched. Every item gives exactly one result.
// Flow: after reset the table clears the occupied marks and face vectors of
// every slot; items are buffered but not processed during that sweep. The
// front end takes an item, finds its home slot (a reciprocal multiply of the key
// in two halves, then the remainder) and hands it into a 2-entry queue; it takes
// no new item until that one is handed on. The probe engine reads one slot per
// cycle from the table memory and visits 1 to SLOTS slots per item, starting the
// next item only once the probe ends. A face out of range skips the probe. The
// result sits in an output register; the engine starts the next item only once
// that register is free or being taken, while the front end and queue keep
// accepting until the queue is full.
module pending_interest_probe_table #(
   parameter int SLOTS      = pipt_pkg::SLOTS_DEF,
   parameter int FACE_COUNT = pipt_pkg::FACE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pipt_pkg::CMD_W-1:0]    req_command,
   input  logic [pipt_pkg::FP_W-1:0]     req_fingerprint,
   input  logic [pipt_pkg::FACE_W-1:0]   req_face,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pipt_pkg::STAT_W-1:0]   rsp_status,
   output logic [pipt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_found,
   output logic                          rsp_requested
);
   import pipt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int Q_W   = ITEM_W + IDX_W;

   // Front to queue
   logic             fq_valid;
   logic             fq_ready;
   item_type         fq_item;
   logic [IDX_W-1:0] fq_home;

   // Queue to back
   logic             qb_valid;
   logic             qb_ready;
   logic [Q_W-1:0]   qb_data;
   item_type         qb_item;
   logic [IDX_W-1:0] qb_home;

   // Classify the item and find its home slot
   pipt_front #(
      .SLOTS      (SLOTS),
      .FACE_COUNT (FACE_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_fingerprint (req_fingerprint),
      .req_face        (req_face),
      .push_valid      (fq_valid),
      .push_ready      (fq_ready),
      .push_item       (fq_item),
      .push_home       (fq_home)
   );

   // Hold classified items so the front keeps accepting during long probes
   pipt_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  ({fq_item, fq_home}),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   assign qb_item = item_type'(qb_data[Q_W-1:IDX_W]);
   assign qb_home = qb_data[IDX_W-1:0];

   // Walk the table and drive the result register
   pipt_back #(
      .SLOTS      (SLOTS),
      .FACE_COUNT (FACE_COUNT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (qb_valid),
      .pop_ready     (qb_ready),
      .pop_item      (qb_item),
      .pop_home      (qb_home),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_found     (rsp_found),
      .rsp_requested (rsp_requested)
   );

endmodule

@@ bench/pending_interest_probe_table_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the pending interest probe table.
module pending_interest_probe_table_tb;

   localparam int SLOT_COUNT = pipt_pkg::SLOTS_DEF;
   localparam int FACES      = pipt_pkg::FACE_COUNT_DEF;
   localparam int RANDOM_ITEMS = 1000;

   // One result item as the table reports it
   typedef struct packed {
      pipt_pkg::status_type              status;
      logic [pipt_pkg::SLOT_W-1:0]       slot;
      logic                              found;
      logic                              requested;
   } reply_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_SPARSE
   } rx_mode_type;

   logic                            clock;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_ready;
   logic [pipt_pkg::CMD_W-1:0]      req_command     = '0;
   logic [pipt_pkg::FP_W-1:0]       req_fingerprint = '0;
   logic [pipt_pkg::FACE_W-1:0]     req_face        = '0;
   logic                            rsp_valid;
   logic                            rsp_ready       = 1'b0;
   logic [pipt_pkg::STAT_W-1:0]     rsp_status;
   logic [pipt_pkg::SLOT_W-1:0]     rsp_slot;
   logic                            rsp_found;
   logic                            rsp_requested;

   // Shadow copy of the table contents, updated as each item is accepted
   logic [pipt_pkg::FP_W-1:0]       shadow_key   [SLOT_COUNT];
   logic [FACES-1:0]                shadow_faces [SLOT_COUNT];
   logic                            shadow_used  [SLOT_COUNT];

   // Results predicted but not yet seen, oldest first
   reply_type                       replies_due[$];
   // Fingerprints that made it into the table, for hits and home-slot aliases
   logic [pipt_pkg::FP_W-1:0]       filed_keys[$];

   rx_mode_type                     ready_mode  = RX_OPEN;
   int unsigned                     ready_left  = 0;
   logic [2:0]                      ready_phase = '0;

   int unsigned mismatches   = 0;
   int unsigned items_sent   = 0;
   int unsigned n_inserted   = 0;
   int unsigned n_full       = 0;
   int unsigned n_bad_face   = 0;
   int unsigned n_hit        = 0;
   int unsigned n_miss       = 0;

   pending_interest_probe_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_fingerprint (req_fingerprint),
      .req_face        (req_face),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_found       (rsp_found),
      .rsp_requested   (rsp_requested)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the table hangs; far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_key[i]   = '0;
         shadow_faces[i] = '0;
         shadow_used[i]  = 1'b0;
      end
   end

   // Walk the probe path for one item, apply any insert to the shadow table
   // and return the result the table must give for it.
   function automatic reply_type walk_probe_path(pipt_pkg::cmd_type cmd,
                                                 logic [pipt_pkg::FP_W-1:0] fp,
                                                 logic [pipt_pkg::FACE_W-1:0] face);
      int unsigned idx;
      reply_type   r;
      r.status    = pipt_pkg::ST_CHECKED;
      r.slot      = '0;
      r.found     = 1'b0;
      r.requested = 1'b0;
      idx = fp % SLOT_COUNT;
      // A face outside the face vector is refused before any probing
      if (face >= FACES) begin
         r.status = pipt_pkg::ST_BAD_FACE;
         return r;
      end
      if (cmd == pipt_pkg::CMD_INSERT) begin
         // Claim the first free slot from home onward, even for a repeated key
         for (int n = 0; n < SLOT_COUNT; n++) begin
            if (!shadow_used[idx]) begin
               shadow_key[idx]         = fp;
               shadow_faces[idx][face] = 1'b1;
               shadow_used[idx]        = 1'b1;
               r.status = pipt_pkg::ST_INSERTED;
               r.slot   = idx[pipt_pkg::SLOT_W-1:0];
               return r;
            end
            idx = (idx + 1) % SLOT_COUNT;
         end
         r.status = pipt_pkg::ST_FULL;
         return r;
      end
      // Check: stop at a free slot, at the first matching key, or after a full wrap
      for (int n = 0; n < SLOT_COUNT; n++) begin
         if (!shadow_used[idx])
            break;
         if (shadow_key[idx] == fp) begin
            r.slot      = idx[pipt_pkg::SLOT_W-1:0];
            r.found     = 1'b1;
            r.requested = shadow_faces[idx][face];
            return r;
         end
         idx = (idx + 1) % SLOT_COUNT;
      end
      return r;
   endfunction

   // Present one item and hold it until the table takes it. Called at a rising
   // edge; returns at the edge of acceptance with valid still high, so the
   // next item can follow back to back.
   task automatic send_item(input pipt_pkg::cmd_type cmd,
                            input logic [pipt_pkg::FP_W-1:0] fp,
                            input logic [pipt_pkg::FACE_W-1:0] face,
                            output reply_type rep);
      if (!req_valid)
         req_valid <= 1'b1;
      req_command     <= cmd;
      req_fingerprint <= fp;
      req_face        <= face;
      do
         @(posedge clock);
      while (!req_ready);
      rep = walk_probe_path(cmd, fp, face);
      replies_due.push_back(rep);
      if (rep.status == pipt_pkg::ST_INSERTED)
         filed_keys.push_back(fp);
      items_sent++;
   endtask

   // Probe an empty table and feed out-of-range faces on both commands, just past the last face and at 15.
   task automatic test_empty_table_and_bad_faces();
      reply_type rep;
      send_item(pipt_pkg::CMD_CHECK,  32'h0000_0000, 4'd0, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'hFFFF_FFFF, 4'(FACES - 1), rep);
      send_item(pipt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd15, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'h0000_0000, 4'(FACES), rep);
      send_item(pipt_pkg::CMD_INSERT, 32'h1234_5678, 4'(FACES), rep);
   endtask

   // Fill the ends of the table, force a wrap past the last slot, repeat a
   // key, then check hits on the first copy and a miss that walks the chain.
   task automatic test_insert_and_probe_wrap();
      reply_type rep;
      send_item(pipt_pkg::CMD_INSERT, 32'h0000_0000, 4'd0, rep);
      send_item(pipt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'(FACES - 1), rep);
      send_item(pipt_pkg::CMD_INSERT, 32'h1000_000F, 4'd1, rep);
      send_item(pipt_pkg::CMD_INSERT, 32'h0000_0000, 4'd2, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'h0000_0000, 4'd0, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'h0000_0000, 4'd2, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'h1000_000F, 4'd1, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'h2000_000F, 4'd1, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'hFFFF_FFFF, 4'(FACES - 1), rep);
      send_item(pipt_pkg::CMD_INSERT, 32'hA5A5_A5A5, 4'd2, rep);
      send_item(pipt_pkg::CMD_CHECK,  32'hA5A5_A5A5, 4'(FACES - 1), rep);
   endtask

   // Mostly checks, with rare inserts so the table fills slowly and both the
   // partly empty and the full regimes get long runs. Keys are chosen to hit
   // filed entries, to alias their home slot, or at random.
   task automatic test_random_traffic(input int unsigned count);
      int unsigned                 burst_left;
      int unsigned                 gap;
      int unsigned                 pick;
      pipt_pkg::cmd_type           cmd;
      logic [pipt_pkg::FP_W-1:0]   fp;
      logic [pipt_pkg::FP_W-1:0]   base;
      logic [pipt_pkg::FACE_W-1:0] face;
      reply_type                   rep;
      burst_left = $urandom_range(1, 30);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 3)
            cmd = pipt_pkg::CMD_INSERT;
         else
            cmd = pipt_pkg::CMD_CHECK;
         if (filed_keys.size() != 0)
            base = filed_keys[$urandom_range(0, filed_keys.size() - 1)];
         else
            base = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            fp = base;
         end else if (pick < 75) begin
            // Same home slot, different key: forces probing past mismatches
            fp = $urandom;
            fp = fp - fp % SLOT_COUNT + base % SLOT_COUNT;
         end else begin
            fp = $urandom;
         end
         if ($urandom_range(0, 9) == 0)
            face = 4'($urandom_range(FACES, 15));
         else
            face = 4'($urandom_range(0, FACES - 1));
         send_item(cmd, fp, face, rep);
         // End of burst: drop valid for a while, or sometimes run straight on
         burst_left = burst_left - 1;
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 30);
         end
      end
   endtask

   // Top off the table until an insert is refused, then hit it once more
   // with a refused insert, a check that wraps all the way round, and a
   // bad face against a filed key.
   task automatic test_full_table();
      reply_type rep;
      do
         send_item(pipt_pkg::CMD_INSERT, $urandom, 4'($urandom_range(0, FACES - 1)), rep);
      while (rep.status != pipt_pkg::ST_FULL);
      send_item(pipt_pkg::CMD_INSERT, filed_keys[0], 4'd0, rep);
      send_item(pipt_pkg::CMD_CHECK, $urandom, 4'($urandom_range(0, FACES - 1)), rep);
      send_item(pipt_pkg::CMD_CHECK, filed_keys[filed_keys.size() - 1], 4'd15, rep);
   endtask

   // Receiver: switch among always ready, random stalls and a sparse pattern
   // that is ready only when a free-running 3-bit phase counter is zero.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= rx_mode_type'($urandom_range(0, 2));
         ready_left <= $urandom_range(50, 300);
      end else begin
         ready_left <= ready_left - 1;
      end
      ready_phase <= ready_phase + 3'd1;
      case (ready_mode)
         RX_OPEN: begin
            rsp_ready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 2) != 0);
         end
         default: begin
            rsp_ready <= (ready_phase == 3'd0);
         end
      endcase
   end

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $error("result with no item outstanding: status %0d slot %0d",
                   rsp_status, rsp_slot);
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status) begin
               $error("field status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_slot !== want.slot) begin
               $error("field slot: expected %0d, got %0d", want.slot, rsp_slot);
               mismatches++;
            end
            if (rsp_found !== want.found) begin
               $error("field found: expected %0d, got %0d", want.found, rsp_found);
               mismatches++;
            end
            if (rsp_requested !== want.requested) begin
               $error("field requested: expected %0d, got %0d",
                      want.requested, rsp_requested);
               mismatches++;
            end
            case (want.status)
               pipt_pkg::ST_INSERTED: n_inserted++;
               pipt_pkg::ST_FULL:     n_full++;
               pipt_pkg::ST_BAD_FACE: n_bad_face++;
               default: begin
                  if (want.found)
                     n_hit++;
                  else
                     n_miss++;
               end
            endcase
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_table_and_bad_faces();
      test_insert_and_probe_wrap();
      test_random_traffic(RANDOM_ITEMS);
      test_full_table();
      req_valid <= 1'b0;
      // Drain: wait for every predicted result, then linger past the latency
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("ran %0d items: %0d inserted, %0d refused full, %0d bad faces,",
               items_sent, n_inserted, n_full, n_bad_face);
      $display("%0d checks matched and %0d missed, %0d field mismatches",
               n_hit, n_miss, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
sv/pipt_pkg.sv
sv/pipt_front.sv
sv/pipt_queue.sv
sv/pipt_back.sv
sv/pending_interest_probe_table.sv
bench/pending_interest_probe_table_tb.sv
